/* hdl/assert_macros.svh */
// Assertion helpers for the channel lattice walker.
// Both macros report through $error only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while the synchronous reset is high.
`define CLW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that must hold in every cycle, reset included.
`define CLW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* hdl/clw_pkg.sv */
// Shared types and constants of the channel lattice walker.
// No dependencies; every design module imports this package.
`timescale 1ns / 1ps

package clw_pkg;

  // Work classes handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_START,
    OP_HOP,
    OP_CAPPED
  } op_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_HOP   = 1'b1;

  localparam logic BND_PERIODIC = 1'b0;
  localparam logic BND_REFLECT  = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_XP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_XM        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_YP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT     = 3'd5;

  localparam logic [15:0] RST_CHANNEL_WIDTH = 16'd5;
  localparam logic [39:0] RST_HOP_LIMIT     = 40'd200000000;

  // Mixer and seeding constants.
  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GOLDEN     = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SITE_X_ADD = 64'hD1B54A32D192ED03;
  localparam logic [63:0] SITE_Y_MUL = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] SITE_Y_ADD = 64'h165667B19E3779F9;
  localparam logic [63:0] SEED_KEY   = 64'h5851F42D4C957F2D;
  localparam logic [63:0] DIS_KEY    = 64'hA24BAED4963EE407;

  typedef struct packed {
    logic        command;
    logic [63:0] seed;
  } item_t;

  typedef struct packed {
    logic signed [40:0] x_pos;
    logic [15:0]        y_pos;
    logic [39:0]        hops_done;
    logic [53:0]        site_uniform;
    logic               capped;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [63:0]          wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [53:0] thr_x_plus;
    logic [53:0] thr_x_minus;
    logic [53:0] thr_y_plus;
    logic [15:0] channel_width;
    logic        boundary_mode;
    logic [39:0] hop_limit;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] seed;
  } op_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  function automatic logic [63:0] xorshift33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

/* hdl/clw_chan_if.sv */
// Valid/ready channel carrying one payload word per handshake.
// Payload type comes in as a type parameter; no other dependencies.
`timescale 1ns / 1ps

interface clw_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/channel_lattice_walker_step_core.sv */
// Channel   Dir  Word                                    Accepted when
// item      in   command, seed                           item.valid && item.ready
// result    out  x_pos, y_pos, hops_done, site, capped   result.valid && result.ready
// cfg       in   reg_index, wdata                        cfg.valid && cfg.ready
//
// Products: every 64-bit product goes through one shared 32x32 multiplier, and
//   each item runs two to eight mixer rounds of two products each.
// Reset: rst is synchronous; it clears the walker, generator state, queue and
//   the registers to their reset values (channel width 5, hop limit 200000000).
// Stalls: the queue lets the front keep taking words while the back works, and
//   the result register lets the back start the next word while one waits.
// cfg is always ready; write it only while the block is idle.
//
// Top level of the channel lattice walker: register file and wiring.
// Depends on clw_pkg, clw_chan_if, clw_front, clw_queue, clw_mul, clw_back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module channel_lattice_walker_step_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  clw_chan_if.sink   item,
  clw_chan_if.source result,
  clw_chan_if.sink   cfg
);
  import clw_pkg::*;

  cfg_t      cfg_regs;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  op_entry_t q_wr;
  op_entry_t q_rd;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;

  // Register writes take effect in the cycle after the handshake; unknown indexes drop the word.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '{thr_x_plus: '0, thr_x_minus: '0, thr_y_plus: '0,
                    channel_width: RST_CHANNEL_WIDTH, boundary_mode: BND_PERIODIC,
                    hop_limit: RST_HOP_LIMIT};
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.reg_index)
        CFG_THR_XP:        cfg_regs.thr_x_plus    <= cfg.data.wdata[53:0];
        CFG_THR_XM:        cfg_regs.thr_x_minus   <= cfg.data.wdata[53:0];
        CFG_THR_YP:        cfg_regs.thr_y_plus    <= cfg.data.wdata[53:0];
        CFG_CHANNEL_WIDTH: cfg_regs.channel_width <= cfg.data.wdata[15:0];
        CFG_BOUNDARY_MODE: cfg_regs.boundary_mode <= cfg.data.wdata[0];
        CFG_HOP_LIMIT:     cfg_regs.hop_limit     <= cfg.data.wdata[39:0];
        default:           cfg_regs <= cfg_regs;
      endcase
    end
  end

  // Front: classify each word; it tracks the hop count to spot the limit.
  clw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg     (cfg_regs),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr)
  );

  clw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty)
  );

  clw_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Back: seed, draw, move, hash the site and hold the result word.
  clw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_entry (q_rd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .mul_req (mul_req),
    .mul_rsp (mul_rsp),
    .result  (result)
  );

  `CLW_ASSERT_ALWAYS(a_no_push_full, clk, !(q_push && q_full), "push into full queue")
  `CLW_ASSERT(a_no_pop_empty, clk, rst, q_pop |-> !q_empty, "pop from empty queue")
  `CLW_ASSERT(a_mul_latency, clk, rst, mul_rsp.done |-> $past(mul_req.start, 5), "product without request")

endmodule

/* hdl/clw_front.sv */
// Front part: takes input words, classifies them as start, hop or capped hop.
// Depends on clw_pkg and clw_chan_if.
`timescale 1ns / 1ps

module clw_front (
  input  logic                clk,
  input  logic                rst,
  clw_chan_if.sink            item,
  input  clw_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output clw_pkg::op_entry_t  q_entry
);
  import clw_pkg::*;

  // Shadow of the hop count, kept in step with the back part.
  logic [39:0] hops;
  op_t         op;

  assign item.ready = !q_full;
  assign q_push     = item.valid && item.ready;

  always_comb begin
    op = OP_HOP;
    unique case (item.data.command)
      CMD_START: op = OP_START;
      CMD_HOP:   op = (hops >= cfg.hop_limit) ? OP_CAPPED : OP_HOP;
    endcase
  end

  assign q_entry = '{op: op, seed: item.data.seed};

  always_ff @(posedge clk) begin
    if (rst) begin
      hops <= '0;
    end else if (q_push) begin
      unique case (op)
        OP_START: hops <= '0;
        OP_HOP:   hops <= hops + 40'd1;
        default:  hops <= hops;
      endcase
    end
  end

endmodule

/* hdl/clw_queue.sv */
// Short register queue between the front and back parts.
// Depends on clw_pkg for the entry type.
`timescale 1ns / 1ps

module clw_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  clw_pkg::op_entry_t wr_entry,
  output logic               full,
  input  logic               pop,
  output clw_pkg::op_entry_t rd_entry,
  output logic               empty
);
  import clw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_entry_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/clw_mul.sv */
// Shared 64x64 multiplier keeping the low 64 product bits.
// One 32x32 partial product per cycle; depends on clw_pkg.
`timescale 1ns / 1ps

module clw_mul (
  input  logic              clk,
  input  logic              rst,
  input  clw_pkg::mul_req_t req,
  output clw_pkg::mul_rsp_t rsp
);
  import clw_pkg::*;

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] pp;
  logic [63:0] prod;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // Low-by-low, then the two cross terms; the high-by-high term drops out.
  always_comb begin
    unique case (step)
      2'd1:    begin op_a = a_r[63:32]; op_b = b_r[31:0];  end
      2'd2:    begin op_a = a_r[31:0];  op_b = b_r[63:32]; end
      default: begin op_a = a_r[31:0];  op_b = b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !req.start && busy && (step == 2'd3);
      if (req.start) begin
        a_r  <= req.a;
        b_r  <= req.b;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        pp   <= 64'(op_a) * 64'(op_b);
        step <= step + 2'd1;
        unique case (step)
          2'd1: prod <= pp;
          2'd2: prod[63:32] <= prod[63:32] + pp[31:0];
          2'd3: begin
            prod[63:32] <= prod[63:32] + pp[31:0];
            busy        <= 1'b0;
          end
          default: prod <= prod;
        endcase
      end
    end
  end

  assign rsp = '{done: done, prod: prod};

endmodule

/* hdl/clw_back.sv */
// Back part: seeding, xoshiro256++ draws, walker moves and site hashing.
// Depends on clw_pkg, clw_chan_if and a clw_mul instance in the top level.
`timescale 1ns / 1ps

module clw_back (
  input  logic               clk,
  input  logic               rst,
  input  clw_pkg::cfg_t      cfg,
  input  clw_pkg::op_entry_t q_entry,
  input  logic               q_empty,
  output logic               q_pop,
  output clw_pkg::mul_req_t  mul_req,
  input  clw_pkg::mul_rsp_t  mul_rsp,
  clw_chan_if.source         result
);
  import clw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMIX0,
    S_FMIX1,
    S_FMIX2,
    S_DRAW0,
    S_DRAW1,
    S_MOVE0,
    S_MOVE1,
    S_SITE0,
    S_SITE_X,
    S_SITE1,
    S_SITE_Y,
    S_EMIT
  } state_t;

  // What to do with a finished mix.
  typedef enum logic [2:0] {
    PH_KEY,
    PH_WORD,
    PH_DIS,
    PH_SX,
    PH_SY
  } phase_t;

  state_t      state;
  phase_t      phase;
  logic [1:0]  wcnt;
  logic [63:0] acc;
  logic [63:0] kreg;
  logic [63:0] seed_r;
  logic [63:0] words [4];
  logic [63:0] key;
  logic [40:0] wx;
  logic [15:0] wy;
  logic [39:0] hops;
  logic        capped_r;
  logic [63:0] sum;
  logic [63:0] rnd;
  logic [53:0] u;
  logic [53:0] site;
  logic        res_valid;
  result_t     res_data;

  logic [63:0] fm_res;
  logic [63:0] t17;
  logic [63:0] n0, n1, n2, n3;
  logic [15:0] w_eff;
  logic [16:0] y_inc;
  logic [15:0] y_up;
  logic [15:0] y_dn;

  assign q_pop        = (state == S_IDLE) && !q_empty;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  assign fm_res = xorshift33(mul_rsp.prod);

  // xoshiro256++ state advance.
  always_comb begin
    t17 = words[1] << 17;
    n2  = words[2] ^ words[0];
    n3  = words[3] ^ words[1];
    n1  = words[1] ^ n2;
    n0  = words[0] ^ n3;
  end

  // Transverse move candidates.
  always_comb begin
    w_eff = (cfg.channel_width == '0) ? 16'd1 : cfg.channel_width;
    y_inc = {1'b0, wy} + 17'd1;
    unique case (cfg.boundary_mode)
      BND_PERIODIC: begin
        y_up = (y_inc >= {1'b0, w_eff}) ? 16'd0 : y_inc[15:0];
        y_dn = (wy == '0) ? w_eff - 16'd1 : wy - 16'd1;
      end
      BND_REFLECT: begin
        y_up = (y_inc < {1'b0, w_eff}) ? y_inc[15:0] : wy;
        y_dn = (wy == '0) ? wy : wy - 16'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_KEY;
      wcnt        <= '0;
      words       <= '{default: '0};
      key         <= '0;
      wx          <= '0;
      wy          <= '0;
      hops        <= '0;
      capped_r    <= 1'b0;
      mul_req     <= '0;
      res_valid   <= 1'b0;
    end else begin
      // Pulse the multiplier start from every state that issues a product.
      mul_req.start <= (state == S_FMIX0) || (state == S_SITE0) || (state == S_SITE1) ||
                       ((state == S_FMIX1) && mul_rsp.done);
      if (res_valid && result.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (q_entry.op)
              OP_START: begin
                seed_r   <= q_entry.seed;
                acc      <= q_entry.seed ^ SEED_KEY;
                phase    <= PH_KEY;
                capped_r <= 1'b0;
                state    <= S_FMIX0;
              end
              OP_HOP: begin
                capped_r <= 1'b0;
                state    <= S_DRAW0;
              end
              OP_CAPPED: begin
                capped_r <= 1'b1;
                state    <= S_SITE0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FMIX0: begin
          mul_req.a <= xorshift33(acc);
          mul_req.b <= FMIX_C1;
          state     <= S_FMIX1;
        end
        S_FMIX1: begin
          if (mul_rsp.done) begin
            mul_req.a <= fm_res;
            mul_req.b <= FMIX_C2;
            state     <= S_FMIX2;
          end
        end
        S_FMIX2: begin
          if (mul_rsp.done) begin
            unique case (phase)
              PH_KEY: begin
                kreg  <= fm_res + GOLDEN;
                acc   <= fm_res + GOLDEN;
                wcnt  <= '0;
                phase <= PH_WORD;
                state <= S_FMIX0;
              end
              PH_WORD: begin
                // shift in so the first word lands in slot 0
                words[0] <= words[1];
                words[1] <= words[2];
                words[2] <= words[3];
                words[3] <= fm_res;
                if (wcnt == 2'd3) begin
                  acc   <= seed_r ^ DIS_KEY;
                  phase <= PH_DIS;
                end else begin
                  kreg <= kreg + GOLDEN;
                  acc  <= kreg + GOLDEN;
                  wcnt <= wcnt + 2'd1;
                end
                state <= S_FMIX0;
              end
              PH_DIS: begin
                key <= fm_res;
                if ((words[0] | words[1] | words[2] | words[3]) == '0) begin
                  words[0] <= 64'd1;
                end
                wx    <= '0;
                wy    <= '0;
                hops  <= '0;
                state <= S_SITE0;
              end
              PH_SX: begin
                acc   <= key ^ fm_res;
                state <= S_SITE1;
              end
              PH_SY: begin
                site  <= {1'b0, fm_res[63:11]} + 54'd1;
                state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DRAW0: begin
          sum   <= words[0] + words[3];
          state <= S_DRAW1;
        end
        S_DRAW1: begin
          rnd      <= {sum[40:0], sum[63:41]} + words[0];
          words[0] <= n0;
          words[1] <= n1;
          words[2] <= n2 ^ t17;
          words[3] <= {n3[18:0], n3[63:19]};
          state    <= S_MOVE0;
        end
        S_MOVE0: begin
          u     <= {1'b0, rnd[63:11]} + 54'd1;
          state <= S_MOVE1;
        end
        S_MOVE1: begin
          priority if (u < cfg.thr_x_plus) begin
            wx <= wx + 41'd1;
          end else if (u < cfg.thr_x_minus) begin
            wx <= wx - 41'd1;
          end else if (u < cfg.thr_y_plus) begin
            wy <= y_up;
          end else begin
            wy <= y_dn;
          end
          hops  <= hops + 40'd1;
          state <= S_SITE0;
        end
        S_SITE0: begin
          mul_req.a <= {{23{wx[40]}}, wx};
          mul_req.b <= GOLDEN;
          state     <= S_SITE_X;
        end
        S_SITE_X: begin
          if (mul_rsp.done) begin
            acc   <= mul_rsp.prod + SITE_X_ADD;
            phase <= PH_SX;
            state <= S_FMIX0;
          end
        end
        S_SITE1: begin
          mul_req.a <= {48'd0, wy};
          mul_req.b <= SITE_Y_MUL;
          state     <= S_SITE_Y;
        end
        S_SITE_Y: begin
          if (mul_rsp.done) begin
            acc   <= acc ^ (mul_rsp.prod + SITE_Y_ADD);
            phase <= PH_SY;
            state <= S_FMIX0;
          end
        end
        S_EMIT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_data  <= '{x_pos: $signed(wx), y_pos: wy, hops_done: hops,
                           site_uniform: site, capped: capped_r};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
